// ----- sv/pcbt_pkg.sv -----
// shared constants, codes and the tally entry type of the per-command byte tally
package pcbt_pkg;

  localparam int NUM_IDS = 256;
  localparam int MAX_TOP = 64;
  localparam int ID_AW   = $clog2(NUM_IDS);

  localparam int KIND_W  = 2;
  localparam int CMD_W   = 8;
  localparam int CNT_W   = 16;
  localparam int TOP_W   = 7;
  localparam int BYTES_W = 64;
  localparam int MSGS_W  = 32;

  localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [MSGS_W-1:0]  msgs;
  } tally_t;

  localparam int TALLY_W = $bits(tally_t);

endpackage

// ----- sv/pcbt_ram.sv -----
// generic single-write, single-read ram with registered read data
module pcbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

endmodule

// ----- sv/per_command_byte_tally_top_n_top.sv -----
// top level of the per-command byte tally with top-n report
//
//   port group  dir  handshake          payload
//   in_         in   in_valid/in_stall  kind, command_id, byte_count, top_count
//   out_        out  out_valid/out_stall entry_valid, listed_id, listed_bytes,
//                                       listed_messages, grand_total, last
//
// record items: one per cycle if idle, ram read, add, writeback, last write forwarded
// clear items and reset: a clearing sweep of all NUM_IDS ids with input stalled
// report: one ram scan of all ids per listed id, one more scan when fewer
// ids than asked hold bytes, one output item per result; input stalled throughout
// an output stall holds the report at its result register until the item is taken
module per_command_byte_tally_top_n_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pcbt_pkg::KIND_W-1:0]   in_kind,
  input  logic [pcbt_pkg::CMD_W-1:0]    in_command_id,
  input  logic [pcbt_pkg::CNT_W-1:0]    in_byte_count,
  input  logic [pcbt_pkg::TOP_W-1:0]    in_top_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_entry_valid,
  output logic [pcbt_pkg::CMD_W-1:0]    out_listed_id,
  output logic [pcbt_pkg::BYTES_W-1:0]  out_listed_bytes,
  output logic [pcbt_pkg::MSGS_W-1:0]   out_listed_messages,
  output logic [pcbt_pkg::BYTES_W-1:0]  out_grand_total,
  output logic                          out_last
);
  import pcbt_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam logic [ID_AW-1:0] LAST_ID = ID_AW'(NUM_IDS - 1);
  localparam logic [TOP_W-1:0] TOP_SAT = TOP_W'(MAX_TOP);

  logic [2:0]         state_r, state_nxt;
  logic [ID_AW-1:0]   scan_r, scan_nxt;
  logic [ID_AW-1:0]   rd_id_r;
  logic               rec_v_r, rec_v_nxt;
  logic [CNT_W-1:0]   rec_cnt_r;
  logic               lw_v_r;
  logic [ID_AW-1:0]   lw_id_r;
  tally_t             lw_data_r;
  logic               chk_v_r, chk_v_nxt;
  logic               best_v_r, best_v_nxt;
  logic [BYTES_W-1:0] best_b_r, best_b_nxt;
  logic [ID_AW-1:0]   best_id_r, best_id_nxt;
  logic [MSGS_W-1:0]  best_m_r, best_m_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [BYTES_W-1:0] pend_b_r, pend_b_nxt;
  logic [ID_AW-1:0]   pend_id_r, pend_id_nxt;
  logic [MSGS_W-1:0]  pend_m_r, pend_m_nxt;
  logic [TOP_W-1:0]   list_r, list_nxt;
  logic [TOP_W-1:0]   want_r, want_nxt;
  logic               emit_last_r, emit_last_nxt;
  logic [BYTES_W-1:0] total_r, total_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ev_r, out_ev_nxt;
  logic [CMD_W-1:0]   out_id_r, out_id_nxt;
  logic [BYTES_W-1:0] out_b_r, out_b_nxt;
  logic [MSGS_W-1:0]  out_m_r, out_m_nxt;
  logic [BYTES_W-1:0] out_tot_r, out_tot_nxt;
  logic               out_last_r, out_last_nxt;

  logic               accept;
  logic               in_range;
  logic               out_free;
  logic [TOP_W-1:0]   want_sat;
  logic [TOP_W-1:0]   list_inc;
  logic [ID_AW-1:0]   raddr;
  logic               we;
  logic [ID_AW-1:0]   waddr;
  tally_t             wdata;
  logic [TALLY_W-1:0] ram_rd;
  tally_t             fwd;
  logic               elig;
  logic               take;

  pcbt_ram #(
    .WIDTH (TALLY_W),
    .DEPTH (NUM_IDS)
  ) u_tally_ram (
    .clk       (clk),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rd_data_r (ram_rd)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(in_command_id) < NUM_IDS);
  assign out_free = !out_valid_r || !out_stall;
  assign want_sat = (in_top_count > TOP_SAT) ? TOP_SAT : in_top_count;
  assign list_inc = list_r + TOP_W'(1);
  assign raddr    = (state_r == ST_SCAN) ? scan_r : ID_AW'(in_command_id);

  // last write forwarded over the ram read latency
  assign fwd = (lw_v_r && (lw_id_r == rd_id_r)) ? lw_data_r : tally_t'(ram_rd);

  assign elig = chk_v_r && (fwd.bytes != '0) &&
                (!pend_v_r || (fwd.bytes < pend_b_r) ||
                 ((fwd.bytes == pend_b_r) && (rd_id_r > pend_id_r)));
  assign take = elig && (!best_v_r || (fwd.bytes > best_b_r));

  always_comb begin
    we    = 1'b0;
    waddr = rd_id_r;
    wdata = '{bytes: fwd.bytes + BYTES_W'(rec_cnt_r), msgs: fwd.msgs + MSGS_W'(1)};
    if (state_r == ST_CLEAR) begin
      we    = 1'b1;
      waddr = scan_r;
      wdata = '0;
    end else if (rec_v_r) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    rec_v_nxt     = accept && (in_kind == KIND_RECORD) && (in_byte_count != '0) && in_range;
    chk_v_nxt     = 1'b0;
    best_v_nxt    = best_v_r;
    best_b_nxt    = best_b_r;
    best_id_nxt   = best_id_r;
    best_m_nxt    = best_m_r;
    pend_v_nxt    = pend_v_r;
    pend_b_nxt    = pend_b_r;
    pend_id_nxt   = pend_id_r;
    pend_m_nxt    = pend_m_r;
    list_nxt      = list_r;
    want_nxt      = want_r;
    emit_last_nxt = emit_last_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ev_nxt    = out_ev_r;
    out_id_nxt    = out_id_r;
    out_b_nxt     = out_b_r;
    out_m_nxt     = out_m_r;
    out_tot_nxt   = out_tot_r;
    out_last_nxt  = out_last_r;

    if (take) begin
      best_v_nxt  = 1'b1;
      best_b_nxt  = fwd.bytes;
      best_id_nxt = rd_id_r;
      best_m_nxt  = fwd.msgs;
    end

    case (state_r)
      ST_CLEAR: begin
        scan_nxt = scan_r + ID_AW'(1);
        if (scan_r == LAST_ID) begin
          scan_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_RECORD: begin
              if (rec_v_nxt) begin
                total_nxt = total_r + BYTES_W'(in_byte_count);
              end
            end
            KIND_CLEAR: begin
              total_nxt = '0;
              scan_nxt  = '0;
              state_nxt = ST_CLEAR;
            end
            KIND_REPORT: begin
              pend_v_nxt = 1'b0;
              list_nxt   = '0;
              want_nxt   = want_sat;
              if (want_sat == '0) begin
                emit_last_nxt = 1'b1;
                state_nxt     = ST_EMIT;
              end else begin
                scan_nxt   = '0;
                best_v_nxt = 1'b0;
                state_nxt  = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        chk_v_nxt = 1'b1;
        scan_nxt  = scan_r + ID_AW'(1);
        if (scan_r == LAST_ID) begin
          scan_nxt  = '0;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (pend_v_r) begin
          emit_last_nxt = !best_v_r;
          state_nxt     = ST_EMIT;
        end else if (best_v_r) begin
          pend_v_nxt  = 1'b1;
          pend_b_nxt  = best_b_r;
          pend_id_nxt = best_id_r;
          pend_m_nxt  = best_m_r;
          list_nxt    = TOP_W'(1);
          if (want_r == TOP_W'(1)) begin
            emit_last_nxt = 1'b1;
            state_nxt     = ST_EMIT;
          end else begin
            scan_nxt   = '0;
            best_v_nxt = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end else begin
          emit_last_nxt = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = pend_v_r;
          out_id_nxt    = pend_v_r ? CMD_W'(pend_id_r) : '0;
          out_b_nxt     = pend_v_r ? pend_b_r : '0;
          out_m_nxt     = pend_v_r ? pend_m_r : '0;
          out_tot_nxt   = total_r;
          out_last_nxt  = emit_last_r;
          if (emit_last_r) begin
            pend_v_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end else begin
            pend_b_nxt  = best_b_r;
            pend_id_nxt = best_id_r;
            pend_m_nxt  = best_m_r;
            list_nxt    = list_inc;
            if (list_inc == want_r) begin
              emit_last_nxt = 1'b1;
            end else begin
              scan_nxt   = '0;
              best_v_nxt = 1'b0;
              state_nxt  = ST_SCAN;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      scan_r      <= '0;
      rec_v_r     <= 1'b0;
      lw_v_r      <= 1'b0;
      chk_v_r     <= 1'b0;
      best_v_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      rec_v_r     <= rec_v_nxt;
      lw_v_r      <= we;
      chk_v_r     <= chk_v_nxt;
      best_v_r    <= best_v_nxt;
      pend_v_r    <= pend_v_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_id_r     <= raddr;
    rec_cnt_r   <= in_byte_count;
    lw_id_r     <= waddr;
    lw_data_r   <= wdata;
    best_b_r    <= best_b_nxt;
    best_id_r   <= best_id_nxt;
    best_m_r    <= best_m_nxt;
    pend_b_r    <= pend_b_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_m_r    <= pend_m_nxt;
    list_r      <= list_nxt;
    want_r      <= want_nxt;
    emit_last_r <= emit_last_nxt;
    out_ev_r    <= out_ev_nxt;
    out_id_r    <= out_id_nxt;
    out_b_r     <= out_b_nxt;
    out_m_r     <= out_m_nxt;
    out_tot_r   <= out_tot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_entry_valid     = out_ev_r;
  assign out_listed_id       = out_id_r;
  assign out_listed_bytes    = out_b_r;
  assign out_listed_messages = out_m_r;
  assign out_grand_total     = out_tot_r;
  assign out_last            = out_last_r;

endmodule
